// File: src/three_marker_rle_decoder_assert.svh
// Assertion macros for the run-length decoder modules
`ifndef THREE_MARKER_RLE_DECODER_ASSERT_SVH
`define THREE_MARKER_RLE_DECODER_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define TMRLED_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define TMRLED_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tmrled_pkg.sv
// Shared types and constants of the run-length decoder
package tmrled_pkg;

  // Bytes carried by one result word and the width of its byte count
  localparam int OUT_BYTES = 4;
  localparam int COUNT_W   = 3;

  // Longest run is 256 bytes, so a length needs nine bits
  localparam int LEN_W = 9;

  // Depth of the command queue between parser and expander
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One run command: a byte value repeated len times
  typedef struct packed {
    logic [7:0]       value;
    logic [LEN_W-1:0] len;
  } run_cmd_t;

endpackage

// File: src/tmrled_front.sv
// Stream parser: tracks header and code phases of accepted words and issues run commands
module tmrled_front import tmrled_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic [7:0] in_byte,
  input  logic     block_start,
  input  logic     q_full,
  output logic     push,
  output run_cmd_t push_cmd
);

  typedef enum logic [6:0] {
    PH_HDR_FMARK = 7'b0000001,
    PH_HDR_FVAL  = 7'b0000010,
    PH_HDR_EMARK = 7'b0000100,
    PH_CODE      = 7'b0001000,
    PH_FILL_CNT  = 7'b0010000,
    PH_ESC_VAL   = 7'b0100000,
    PH_ESC_CNT   = 7'b1000000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] fill_marker, fill_marker_next;
  logic [7:0] fill_value, fill_value_next;
  logic [7:0] escape_marker, escape_marker_next;
  logic [7:0] escape_value, escape_value_next;
  logic       accept;
  logic [LEN_W-1:0] count_len;

  // Hold the input while the queue has no room
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign count_len = LEN_W'({1'b0, in_byte}) + LEN_W'(1);

  // Decode the accepted word against the current phase
  always_comb begin
    phase_next         = phase;
    fill_marker_next   = fill_marker;
    fill_value_next    = fill_value;
    escape_marker_next = escape_marker;
    escape_value_next  = escape_value;
    push               = 1'b0;
    push_cmd.value     = in_byte;
    push_cmd.len       = LEN_W'(1);
    if (accept) begin
      if (block_start) begin
        // A block start always opens a new header and drops any pending code
        fill_marker_next = in_byte;
        phase_next       = PH_HDR_FVAL;
      end else begin
        case (phase)
          PH_HDR_FVAL: begin
            fill_value_next = in_byte;
            phase_next      = PH_HDR_EMARK;
          end
          PH_HDR_EMARK: begin
            escape_marker_next = in_byte;
            phase_next         = PH_CODE;
          end
          PH_CODE: begin
            // Fill marker wins when both markers match
            if (in_byte == fill_marker) begin
              phase_next = PH_FILL_CNT;
            end else if (in_byte == escape_marker) begin
              phase_next = PH_ESC_VAL;
            end else begin
              push = 1'b1;
            end
          end
          PH_FILL_CNT: begin
            push           = 1'b1;
            push_cmd.value = fill_value;
            push_cmd.len   = count_len;
            phase_next     = PH_CODE;
          end
          PH_ESC_VAL: begin
            escape_value_next = in_byte;
            phase_next        = PH_ESC_CNT;
          end
          PH_ESC_CNT: begin
            push           = 1'b1;
            push_cmd.value = escape_value;
            push_cmd.len   = count_len;
            phase_next     = PH_CODE;
          end
          default: begin
            // Awaiting a header: take the word as the fill marker
            fill_marker_next = in_byte;
            phase_next       = PH_HDR_FVAL;
          end
        endcase
      end
    end
  end

  // Advance phase and markers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR_FMARK;
      fill_marker   <= 8'h00;
      fill_value    <= 8'h00;
      escape_marker <= 8'h00;
      escape_value  <= 8'h00;
    end else begin
      phase         <= phase_next;
      fill_marker   <= fill_marker_next;
      fill_value    <= fill_value_next;
      escape_marker <= escape_marker_next;
      escape_value  <= escape_value_next;
    end
  end

endmodule

// File: src/tmrled_queue.sv
// Small register queue of run commands between parser and expander
module tmrled_queue import tmrled_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  run_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output run_cmd_t q_cmd
);

  run_cmd_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full    = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_cmd   = slots[rd_ptr];

  // Store an incoming command
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

// File: src/tmrled_back.sv
// Run expander: turns run commands into packed result words
`include "three_marker_rle_decoder_assert.svh"
module tmrled_back import tmrled_pkg::*; #(
  parameter int BYTES_PER_WORD = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  run_cmd_t           q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8*OUT_BYTES-1:0] out_word,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_last
);

  // Effective word size is clamped to what the result word holds
  localparam int WORD_BYTES = (BYTES_PER_WORD < 1) ? 1 :
                              ((BYTES_PER_WORD > OUT_BYTES) ? OUT_BYTES : BYTES_PER_WORD);
  localparam logic [LEN_W-1:0]   WB_LEN = LEN_W'(WORD_BYTES);
  localparam logic [COUNT_W-1:0] WB_CNT = COUNT_W'(WORD_BYTES);

  logic                   busy;
  logic [7:0]             value;
  logic [LEN_W-1:0]       rem;
  logic                   emit;
  logic                   emit_last;
  logic [COUNT_W-1:0]     emit_count;
  logic [8*OUT_BYTES-1:0] word_next;

  // Produce a word whenever a run is active and the output slot frees up
  assign emit       = busy && (!out_valid || !out_stall);
  assign emit_last  = (rem <= WB_LEN);
  assign emit_count = emit_last ? rem[COUNT_W-1:0] : WB_CNT;
  assign pop        = q_valid && (!busy || (emit && emit_last));

  // Replicate the run byte into the valid lanes, zero the rest
  always_comb begin
    for (int i = 0; i < OUT_BYTES; i++) begin
      word_next[8*i +: 8] = (COUNT_W'(i) < emit_count) ? value : 8'h00;
    end
  end

  // Track the active run
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      value <= 8'h00;
      rem   <= '0;
    end else if (pop) begin
      busy  <= 1'b1;
      value <= q_cmd.value;
      rem   <= q_cmd.len;
    end else if (emit) begin
      busy <= !emit_last;
      rem  <= rem - LEN_W'(emit_count);
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word  <= word_next;
      out_count <= emit_count;
      out_last  <= emit_last;
    end
  end

  `TMRLED_ASSERT_IMP(a_count_range, clk, rst, out_valid,
    (out_count != '0 && out_count <= WB_CNT), "result byte count out of range")
  `TMRLED_ASSERT_IMP(a_rem_nonzero, clk, rst, busy, (rem != '0),
    "active run with nothing left")
  `TMRLED_ASSERT_NXT(a_run_ends, clk, rst, (emit && emit_last && !q_valid), !busy,
    "expander still busy after last word")

endmodule

// File: src/three_marker_rle_decoder.sv
// Three-marker run-length decoder: header parser, command queue, run expander.
// Throughput: one result word per cycle while out_stall is low and runs are queued;
// a run of n+1 bytes is split into words of up to BYTES_PER_WORD bytes (at most four),
// a literal gives a one-byte word, and header words give none.
// Reset (rst, synchronous) returns the parser to awaiting a header and empties
// the queue and output register.
module three_marker_rle_decoder import tmrled_pkg::*; #(
  parameter int BYTES_PER_WORD = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               block_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8*OUT_BYTES-1:0] out_word,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_last
);

  logic     q_full;
  logic     push;
  run_cmd_t push_cmd;
  logic     pop;
  logic     q_valid;
  run_cmd_t q_cmd;

  tmrled_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .block_start (block_start),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  tmrled_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tmrled_back #(
    .BYTES_PER_WORD (BYTES_PER_WORD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .out_count (out_count),
    .out_last  (out_last)
  );

endmodule

// File: tb/tmrled_checker.sv
// Checker for the run-length decoder: decodes the accepted input words and compares result words
module tmrled_checker import tmrled_pkg::*; #(
  parameter int BYTES_PER_WORD = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             in_byte,
  input  logic                   block_start,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [8*OUT_BYTES-1:0] out_word,
  input  logic [COUNT_W-1:0]     out_count,
  input  logic                   out_last,
  output int                     fail_count,
  output int                     words_pending
);

  // Bytes packed per result word, held to what out_word can carry
  localparam int WORD_BYTES = (BYTES_PER_WORD < 1) ? 1 :
                              (BYTES_PER_WORD > OUT_BYTES) ? OUT_BYTES : BYTES_PER_WORD;
  localparam int REPORT_MAX = 10;

  typedef enum logic [2:0] {
    AWAIT_FMARK,
    AWAIT_FVAL,
    AWAIT_EMARK,
    AWAIT_CODE,
    AWAIT_FCNT,
    AWAIT_EVAL,
    AWAIT_ECNT
  } dec_phase_t;

  typedef struct packed {
    logic [8*OUT_BYTES-1:0] word;
    logic [COUNT_W-1:0]     count;
    logic                   last;
  } result_word_t;

  dec_phase_t   phase;
  logic [7:0]   fill_mark;
  logic [7:0]   fill_byte;
  logic [7:0]   esc_mark;
  logic [7:0]   esc_byte;
  result_word_t expected_words[$];
  result_word_t head;
  int           mismatch_count;

  // Pack len copies of v into result words, flagging the last
  task automatic queue_run(input logic [7:0] v, input int unsigned len);
    result_word_t w;
    int unsigned  left;
    int unsigned  c;
    left = len;
    while (left > 0) begin
      c = (left < WORD_BYTES) ? left : WORD_BYTES;
      w.word = '0;
      for (int i = 0; i < c; i++) w.word[8*i +: 8] = v;
      w.count = c[COUNT_W-1:0];
      w.last  = (left == c);
      expected_words.push_back(w);
      left -= c;
    end
  endtask

  // Advance the decoder by one accepted input word
  task automatic decode_byte(input logic [7:0] b, input logic s);
    if (s) begin
      fill_mark = b;
      phase     = AWAIT_FVAL;
    end else begin
      case (phase)
        AWAIT_FVAL: begin
          fill_byte = b;
          phase     = AWAIT_EMARK;
        end
        AWAIT_EMARK: begin
          esc_mark = b;
          phase    = AWAIT_CODE;
        end
        AWAIT_CODE: begin
          // fill marker wins when both markers match
          if (b == fill_mark) phase = AWAIT_FCNT;
          else if (b == esc_mark) phase = AWAIT_EVAL;
          else queue_run(b, 1);
        end
        AWAIT_FCNT: begin
          phase = AWAIT_CODE;
          queue_run(fill_byte, int'(b) + 1);
        end
        AWAIT_EVAL: begin
          esc_byte = b;
          phase    = AWAIT_ECNT;
        end
        AWAIT_ECNT: begin
          phase = AWAIT_CODE;
          queue_run(esc_byte, int'(b) + 1);
        end
        default: begin
          // header-awaiting and the unused code both take the fill marker
          fill_mark = b;
          phase     = AWAIT_FVAL;
        end
      endcase
    end
  endtask

  // Predict on accepted input words, compare accepted result words
  always @(posedge clk) begin
    if (rst) begin
      phase     = AWAIT_FMARK;
      fill_mark = '0;
      fill_byte = '0;
      esc_mark  = '0;
      esc_byte  = '0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte, block_start);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result word %h count %0d last %b",
                     out_word, out_count, out_last);
        end else begin
          head = expected_words.pop_front();
          if (out_word !== head.word || out_count !== head.count ||
              out_last !== head.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("expected word %h count %0d last %b, got word %h count %0d last %b",
                       head.word, head.count, head.last, out_word, out_count, out_last);
          end
        end
      end
    end
    words_pending <= expected_words.size();
    fail_count    <= mismatch_count;
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the run-length decoder: clock, reset, stimulus and verdict
module tb_top import tmrled_pkg::*; ();

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 38;
  localparam int SETTLE_TICKS = 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic [7:0]             in_byte = '0;
  logic                   block_start = 1'b0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [8*OUT_BYTES-1:0] out_word;
  logic [COUNT_W-1:0]     out_count;
  logic                   out_last;
  int                     fail_count;
  int                     words_pending;
  int                     send_idle_pct = 11;
  int                     recv_stall_pct = 67;
  int                     words_sent = 0;
  int                     cycle = 0;

  three_marker_rle_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .block_start(block_start),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .out_count  (out_count),
    .out_last   (out_last)
  );

  tmrled_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .block_start  (block_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .out_count    (out_count),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("FAIL three_marker_rle_decoder");
      $finish;
    end
  end

  // Offer one word after a random gap, hold it until accepted
  task automatic send_word(input logic [7:0] b, input logic s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    block_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and hold until every expected result word has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // Run count: mostly short runs, now and then any length up to 256
  function automatic logic [7:0] pick_count();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 7));
  endfunction

  initial begin
    logic [7:0] fm;
    logic [7:0] em;
    int         phase_end;
    int         k;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill marker taken without a block start after reset
    send_word(8'hFF, 1'b0);
    send_word(8'hAA, 1'b0);
    // escape marker equal to fill marker: fill wins
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    // literal zero, then a one-byte fill run
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    // new block with distinct markers, escape run of five, fill run of three
    send_word(8'h12, 1'b1);
    send_word(8'h34, 1'b0);
    send_word(8'h56, 1'b0);
    send_word(8'h56, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h04, 1'b0);
    send_word(8'h12, 1'b0);
    send_word(8'h02, 1'b0);
    // block start in the middle of an escape code drops it
    send_word(8'h56, 1'b0);
    send_word(8'h9A, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h01, 1'b0);
    // block start in the middle of a fill code drops it
    send_word(8'h9A, 1'b0);
    send_word(8'h5C, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    // escape run of the longest length
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    wait_drained();

    // Random blocks under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 11;
          recv_stall_pct = 67;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_end = words_sent + PHASE_ITEMS;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 99) < 8) begin
          // noise word with a random start flag
          send_word(8'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          fm = 8'($urandom);
          em = ($urandom_range(0, 9) == 0) ? fm : 8'($urandom);
          send_word(fm, 1'b1);
          send_word(8'($urandom), 1'b0);
          send_word(em, 1'b0);
          repeat ($urandom_range(1, 8)) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
              send_word(8'($urandom), 1'b0);
            end else if (k < 70) begin
              send_word(fm, 1'b0);
              send_word(pick_count(), 1'b0);
            end else if (k < 95) begin
              send_word(em, 1'b0);
              send_word(8'($urandom), 1'b0);
              send_word(pick_count(), 1'b0);
            end else begin
              // leave an escape code unfinished
              send_word(em, 1'b0);
              send_word(8'($urandom), 1'b0);
            end
          end
        end
        // now and then in the second half of a phase, hold off until the decoder has caught up
        if (words_sent >= phase_end - PHASE_ITEMS / 2 && $urandom_range(0, 9) == 0)
          wait_drained();
      end
      wait_drained();
    end

    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("PASS three_marker_rle_decoder");
    end else begin
      $display("FAIL three_marker_rle_decoder");
    end
    $finish;
  end

endmodule

// File: three_marker_rle_decoder.f
+incdir+src
src/tmrled_pkg.sv
src/tmrled_front.sv
src/tmrled_queue.sv
src/tmrled_back.sv
src/three_marker_rle_decoder.sv
tb/tmrled_checker.sv
tb/tb_top.sv
